>>> hw/rtl/imusfp_pkg.sv
// ----------------------------------------------------------------------------
// imusfp_pkg: shared types and constants of the imu serial frame parser
// frame bytes, parser phases, event codes and the result record
// ----------------------------------------------------------------------------
package imusfp_pkg;

  // frame layout
  localparam int unsigned PAYLOAD_BYTES_DEF = 8;
  localparam int unsigned WORD_LO_IDX       = 4;   // low byte of the 16-bit word
  localparam int unsigned WORD_HI_IDX       = 5;   // high byte of the 16-bit word

  localparam logic [7:0] HDR_BYTE = 8'h55;
  localparam logic [7:0] KIND_ACC = 8'h51;
  localparam logic [7:0] KIND_GYR = 8'h52;
  localparam logic [7:0] KIND_ANG = 8'h53;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_TYPE   = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_SUM    = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_RATE   = 3'd1,
    EV_YAW    = 3'd2,
    EV_ACC    = 3'd3,
    EV_BADSUM = 3'd4
  } event_t;

  typedef struct packed {
    logic signed [15:0] rate_z;
    logic signed [15:0] yaw_angle;
    logic               rate_valid;
    event_t             frame_event;
  } result_t;

endpackage

>>> hw/rtl/imu_serial_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_serial_frame_parser: byte-wise parser for 11-byte sensor frames
// header, type, data bytes and an 8-bit sum checksum; keeps z rate and yaw
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_stall   in_rx_byte[7:0]
//  out_     output     out_valid/out_stall out_rate_z, out_yaw_angle,
//                                          out_rate_valid, out_frame_event
//
//  one byte in every cycle while in_stall is low; each byte yields one registered result
//  the parse state updates in the accept cycle, so only in_stall holds back the byte rate
//  a two-deep output (result register plus skid register) keeps input open
//  while one result waits; in_stall rises only when both are full
//  synchronous active-low reset: header search, sums and kept values zero
//
module imu_serial_frame_parser #(
  parameter int unsigned PAYLOAD_BYTES = imusfp_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // byte request
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_rx_byte,
  // result request
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [15:0]       out_rate_z,
  output logic signed [15:0]       out_yaw_angle,
  output logic                     out_rate_valid,
  output logic [2:0]               out_frame_event
);
  import imusfp_pkg::*;

  // data byte counter, just wide enough to index the payload
  localparam int unsigned CNT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BYTES - 1);
  localparam logic [CNT_W-1:0] CNT_LO   = CNT_W'(WORD_LO_IDX);
  localparam logic [CNT_W-1:0] CNT_HI   = CNT_W'(WORD_HI_IDX);

  // parse state
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [7:0]         kind_r, kind_nxt;
  logic [7:0]         sum_r, sum_nxt;
  // only the two word bytes of the payload are ever read back
  logic [7:0]         lo_r, lo_nxt;
  logic [7:0]         hi_r, hi_nxt;
  logic signed [15:0] rate_r, rate_nxt;
  logic signed [15:0] yaw_r, yaw_nxt;
  logic               seen_r, seen_nxt;
  event_t             ev;

  // output side
  result_t            res;
  result_t            out_r, skid_r;
  logic               out_valid_r, skid_valid_r;
  logic               in_acc, out_take;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  // next parse state for the byte on the input
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    kind_nxt  = kind_r;
    sum_nxt   = sum_r + in_rx_byte;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    rate_nxt  = rate_r;
    yaw_nxt   = yaw_r;
    seen_nxt  = seen_r;
    ev        = EV_NONE;
    case (phase_r)
      PH_HEADER: begin
        sum_nxt = in_rx_byte;
        if (in_rx_byte == HDR_BYTE) begin
          phase_nxt = PH_TYPE;
        end else begin
          sum_nxt = sum_r;
        end
      end
      PH_TYPE: begin
        kind_nxt = in_rx_byte;
        if (in_rx_byte == KIND_ACC || in_rx_byte == KIND_GYR || in_rx_byte == KIND_ANG) begin
          count_nxt = '0;
          phase_nxt = PH_DATA;
        end else begin
          // unknown type: back to header search, this byte is consumed
          phase_nxt = PH_HEADER;
        end
      end
      PH_DATA: begin
        if (count_r == CNT_LO) lo_nxt = in_rx_byte;
        if (count_r == CNT_HI) hi_nxt = in_rx_byte;
        if (count_r == CNT_LAST) begin
          phase_nxt = PH_SUM;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      PH_SUM: begin
        sum_nxt   = sum_r;
        phase_nxt = PH_HEADER;
        if (sum_r == in_rx_byte) begin
          if (kind_r == KIND_GYR) begin
            rate_nxt = {hi_r, lo_r};
            seen_nxt = 1'b1;
            ev       = EV_RATE;
          end else if (kind_r == KIND_ANG) begin
            yaw_nxt = {hi_r, lo_r};
            ev      = EV_YAW;
          end else begin
            ev = EV_ACC;
          end
        end else begin
          ev = EV_BADSUM;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
        sum_nxt   = sum_r;
      end
    endcase
  end

  // result carries the kept values after this byte
  always_comb begin
    res.rate_z      = rate_nxt;
    res.yaw_angle   = yaw_nxt;
    res.rate_valid  = seen_nxt;
    res.frame_event = ev;
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      count_r <= '0;
      kind_r  <= '0;
      sum_r   <= '0;
      rate_r  <= '0;
      yaw_r   <= '0;
      seen_r  <= 1'b0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      kind_r  <= kind_nxt;
      sum_r   <= sum_nxt;
      rate_r  <= rate_nxt;
      yaw_r   <= yaw_nxt;
      seen_r  <= seen_nxt;
    end
  end

  // word bytes are payload, written before every read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  // result register and skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_acc) begin
        out_r <= res;
      end
    end else if (in_acc) begin
      skid_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rate_z      = out_r.rate_z;
  assign out_yaw_angle   = out_r.yaw_angle;
  assign out_rate_valid  = out_r.rate_valid;
  assign out_frame_event = out_r.frame_event;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the result register is empty");

  a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("byte accepted under stall was not parked in the skid register");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (count_r <= CNT_LAST))
    else $error("data byte counter ran past the payload length");

  a_rate_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.frame_event == EV_RATE) |-> out_r.rate_valid)
    else $error("rate update reported without the rate-valid flag");

endmodule
